// File: hdl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the particle density deposit block.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int NUM_BINS  = 128;
  localparam int BIN_AW    = $clog2(NUM_BINS);
  localparam int BIN_W     = 48;
  localparam int CELL_LAST = NUM_BINS - 2;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam logic [17:0]      ONE_Q16 = 18'd65536;
  localparam logic [17:0]      TWO_Q16 = 18'd131072;

  localparam logic [1:0] CFG_GRID_ORIGIN   = 2'd0;
  localparam logic [1:0] CFG_INV_CELL_SIZE = 2'd1;
  localparam logic [1:0] CFG_DEPOSIT_SCALE = 2'd2;

  localparam logic CMD_DEPOSIT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_RDOUT,
    ST_MUL,
    ST_CHECK,
    ST_TAP_MUL,
    ST_TAP_WR
  } pdd_state_t;

endpackage

// File: hdl/pdd_mul.sv
// ----------------------------------------------------------------------------
// pdd_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pdd_mul import pdd_pkg::*; (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// File: hdl/particle_density_deposit.sv
// ----------------------------------------------------------------------------
// particle_density_deposit
// 1D charge deposition onto saturating bin accumulators.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; results come as a
// one-cycle out_strobe that the receiver must take. A read returns the bin
// while clearing it. A deposit first does the coordinate multiply and range
// check (a dropped deposit ends there with a result), then updates two bins
// at an edge cell and four in the interior, each update being a read then
// a write, as the block has a single shared multiplier and a single bin
// memory port. Bins clear at reset through per-bin valid flags, with no
// clearing pass.
module particle_density_deposit import pdd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [31:0]       in_position,
  input  logic [6:0]        in_bin_index,
  output logic              out_strobe,
  output logic              out_result_kind,
  output logic [BIN_W-1:0]  out_bin_value,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  pdd_state_t state_r, state_nxt;

  logic [31:0] grid_origin_r, inv_cell_size_r, deposit_scale_r;

  logic [32:0]        diff_r;
  logic [BIN_AW-1:0]  bidx_r;
  logic [BIN_AW-1:0]  cell_r;
  logic [15:0]        frac_r;
  logic               edge_r;
  logic [1:0]         tap_r;

  logic [BIN_W-1:0]   mem [NUM_BINS];
  logic [BIN_W-1:0]   rdata_r;
  logic               rvalid_r;
  logic [NUM_BINS-1:0] valid_r;

  logic               out_strobe_r, out_kind_r;
  logic [BIN_W-1:0]   out_value_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;

  logic               accept;
  logic               neg, drop, is_edge, tap_last;
  logic [31:0]        cell_idx;
  logic [17:0]        factor;
  logic [BIN_AW-1:0]  tap_addr, mem_addr;
  logic               mem_we;
  logic [BIN_W:0]     sum;
  logic [BIN_W-1:0]   rd_bin, mem_wdata;
  logic               strobe_nxt, kind_nxt;
  logic [BIN_W-1:0]   value_nxt;

  pdd_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign neg      = diff_r[32] && (inv_cell_size_r != 32'd0);
  assign cell_idx = prod[63:32];
  assign drop     = neg || (cell_idx > 32'(CELL_LAST));
  assign is_edge  = (cell_idx == 32'd0) || (cell_idx == 32'(CELL_LAST));
  assign tap_last = edge_r ? (tap_r == 2'd1) : (tap_r == 2'd3);

  assign tap_addr = cell_r + BIN_AW'(tap_r) - (edge_r ? BIN_AW'(0) : BIN_AW'(1));

  always_comb begin
    if (edge_r) begin
      factor = (tap_r == 2'd0) ? (ONE_Q16 - {2'b00, frac_r}) : {2'b00, frac_r};
    end else begin
      unique case (tap_r)
        2'd0: factor = ONE_Q16 - {2'b00, frac_r};
        2'd1: factor = TWO_Q16 - {2'b00, frac_r};
        2'd2: factor = ONE_Q16 + {2'b00, frac_r};
        default: factor = {2'b00, frac_r};
      endcase
    end
  end

  assign rd_bin    = rvalid_r ? rdata_r : '0;
  assign sum       = {1'b0, rd_bin} + (BIN_W+1)'(prod[49:16]);
  assign mem_wdata = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (in_cmd == CMD_READ) ? ST_RD : ST_MUL;
      end
      ST_RD:      state_nxt = ST_RDOUT;
      ST_RDOUT:   state_nxt = ST_IDLE;
      ST_MUL:     state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = drop ? ST_IDLE : ST_TAP_MUL;
      ST_TAP_MUL: state_nxt = ST_TAP_WR;
      ST_TAP_WR:  state_nxt = tap_last ? ST_IDLE : ST_TAP_MUL;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a      = deposit_scale_r;
    mul_b      = {14'd0, factor};
    mem_addr   = tap_addr;
    mem_we     = 1'b0;
    strobe_nxt = 1'b0;
    kind_nxt   = KIND_READ;
    value_nxt  = '0;
    unique case (state_r)
      ST_RD: mem_addr = bidx_r;
      ST_RDOUT: begin
        mem_addr   = bidx_r;
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_READ;
        value_nxt  = rd_bin;
      end
      ST_MUL: begin
        mul_a = diff_r[32] ? 32'd0 : diff_r[31:0];
        mul_b = inv_cell_size_r;
      end
      ST_CHECK: begin
        strobe_nxt = drop;
        kind_nxt   = KIND_DROP;
      end
      ST_TAP_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      grid_origin_r   <= 32'd0;
      inv_cell_size_r <= 32'd65536;
      deposit_scale_r <= 32'd65536;
      valid_r         <= '0;
      tap_r           <= 2'd0;
      out_strobe_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_ORIGIN:   grid_origin_r   <= cfg_wdata;
          CFG_INV_CELL_SIZE: inv_cell_size_r <= cfg_wdata;
          CFG_DEPOSIT_SCALE: deposit_scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_RDOUT) valid_r[bidx_r] <= 1'b0;
      if (mem_we) valid_r[mem_addr] <= 1'b1;
      if (state_r == ST_CHECK) begin
        tap_r <= 2'd0;
      end else if (state_r == ST_TAP_WR) begin
        tap_r <= tap_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= kind_nxt;
    out_value_r <= value_nxt;
    if (accept) begin
      diff_r <= {in_position[31], in_position} - {grid_origin_r[31], grid_origin_r};
      bidx_r <= in_bin_index;
    end
    if (state_r == ST_CHECK) begin
      cell_r <= cell_idx[BIN_AW-1:0];
      frac_r <= prod[31:16];
      edge_r <= is_edge;
    end
  end

  // bin memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r  <= mem[mem_addr];
    rvalid_r <= valid_r[mem_addr];
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_bin_value   = out_value_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted word");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(state_r == ST_RDOUT || state_r == ST_CHECK))
    else $error("result strobe without read or drop");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == KIND_DROP) |-> (out_bin_value == '0))
    else $error("dropped deposit carries nonzero value");

  a_edge_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAP_WR && edge_r) |-> (tap_r == 2'd0 || tap_r == 2'd1))
    else $error("edge cell ran past two bin updates");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(state_r == ST_TAP_MUL))
    else $error("bin write without preceding read");

endmodule
